// ----- rtl/dobq_pkg.sv -----
// ----------------------------------------------------------------------------
// dobq_pkg
// Shared types, codes and defaults for the drop-oldest byte-budget queue.
// ----------------------------------------------------------------------------
package dobq_pkg;

  // default build parameters
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TAG_BITS_DEF    = 16;
  localparam int SIZE_BITS_DEF   = 20;

  // fixed field widths
  localparam int OP_BITS      = 2;
  localparam int STATUS_BITS  = 2;
  localparam int CNT_OUT_BITS = 7;
  localparam int SEQ_BITS     = 32;
  localparam int ME_BITS      = 7;
  localparam int MB_BITS      = 20;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DAT_BITS = 20;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_PUT     = 2'd0;
  localparam logic [OP_BITS-1:0] OP_GET     = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DISCARD = 2'd2;

  // status codes
  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_TOO_BIG = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_BYTES   = 2'd1;

  // register reset values
  localparam logic [ME_BITS-1:0] MAX_ENTRIES_RST = 7'd64;
  localparam logic [MB_BITS-1:0] MAX_BYTES_RST   = 20'd262144;

  typedef struct packed {
    logic [ME_BITS-1:0] max_entries;
    logic [MB_BITS-1:0] max_bytes;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DROP,
    S_POP
  } state_t;

endpackage

// ----- rtl/drop_oldest_byte_budget_queue_core.sv -----
// ----------------------------------------------------------------------------
// drop_oldest_byte_budget_queue_core
// Descriptor FIFO bounded by entry count and total bytes; drops oldest on put.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | operation, item_tag, item_size
//  out     | out_valid / out_ready| status, out_tag, out_size, dropped,
//          |                      | seq_number, entry_count, byte_total
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One word in flight. Rejected or no-drop put, empty pop, unused code: EVAL.
//  Get or discard of a held entry: EVAL, then POP (one ring read).
//  Put dropping k entries: EVAL and DROP k times (a ring read each), then EVAL.
//  Ring state lives in one RAM with registered read; no clearing after reset.
//  A new word is taken while the previous result waits in the output register;
//  the sequencer stalls at its final step until that register frees up.
module drop_oldest_byte_budget_queue_core #(
  parameter int QUEUE_DEPTH = dobq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = dobq_pkg::TAG_BITS_DEF,
  parameter int SIZE_BITS   = dobq_pkg::SIZE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dobq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [dobq_pkg::CFG_DAT_BITS-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dobq_pkg::OP_BITS-1:0]          operation,
  input  logic [TAG_BITS-1:0]                   item_tag,
  input  logic [SIZE_BITS-1:0]                  item_size,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dobq_pkg::STATUS_BITS-1:0]      status,
  output logic [TAG_BITS-1:0]                   out_tag,
  output logic [SIZE_BITS-1:0]                  out_size,
  output logic [dobq_pkg::CNT_OUT_BITS-1:0]     dropped,
  output logic [dobq_pkg::SEQ_BITS-1:0]         seq_number,
  output logic [dobq_pkg::CNT_OUT_BITS-1:0]     entry_count,
  output logic [SIZE_BITS-1:0]                  byte_total
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int RW = TAG_BITS + SIZE_BITS;

  dobq_pkg::cfg_t  cfg;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [RW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [RW-1:0]   ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_entries <= dobq_pkg::MAX_ENTRIES_RST;
      cfg.max_bytes   <= dobq_pkg::MAX_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dobq_pkg::REG_MAX_ENTRIES: cfg.max_entries <= cfg_data[dobq_pkg::ME_BITS-1:0];
        dobq_pkg::REG_MAX_BYTES:   cfg.max_bytes   <= cfg_data[dobq_pkg::MB_BITS-1:0];
        default: ;
      endcase
    end
  end

  dobq_ram #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dobq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .SIZE_BITS   (SIZE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .item_tag    (item_tag),
    .item_size   (item_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_tag     (out_tag),
    .out_size    (out_size),
    .dropped     (dropped),
    .seq_number  (seq_number),
    .entry_count (entry_count),
    .byte_total  (byte_total),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

`ifndef ASSERT_OFF
  // one word at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while previous still in work");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == dobq_pkg::ST_TOO_BIG) |-> (dropped == '0 && seq_number == '0))
    else $error("rejected put reports drops or sequence");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == dobq_pkg::ST_EMPTY) |-> (entry_count == '0 && byte_total == '0))
    else $error("empty status with nonzero occupancy");

  a_drop_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped != '0) |-> (status == dobq_pkg::ST_OK && seq_number != '0 ||
                                      status == dobq_pkg::ST_OK))
    else $error("drops reported on a failed operation");
`endif

endmodule

// ----- rtl/dobq_ram.sv -----
// ----------------------------------------------------------------------------
// dobq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dobq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/dobq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dobq_ctrl
// Queue sequencer: head/count/byte/sequence state, drop loop, result register.
// ----------------------------------------------------------------------------
module dobq_ctrl #(
  parameter int QUEUE_DEPTH = dobq_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = dobq_pkg::TAG_BITS_DEF,
  parameter int SIZE_BITS   = dobq_pkg::SIZE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dobq_pkg::cfg_t                       cfg,
  // item in
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dobq_pkg::OP_BITS-1:0]         operation,
  input  logic [TAG_BITS-1:0]                  item_tag,
  input  logic [SIZE_BITS-1:0]                 item_size,
  // result out
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dobq_pkg::STATUS_BITS-1:0]     status,
  output logic [TAG_BITS-1:0]                  out_tag,
  output logic [SIZE_BITS-1:0]                 out_size,
  output logic [dobq_pkg::CNT_OUT_BITS-1:0]    dropped,
  output logic [dobq_pkg::SEQ_BITS-1:0]        seq_number,
  output logic [dobq_pkg::CNT_OUT_BITS-1:0]    entry_count,
  output logic [SIZE_BITS-1:0]                 byte_total,
  // ring memory
  output logic                                 ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       ram_waddr,
  output logic [TAG_BITS+SIZE_BITS-1:0]        ram_wdata,
  output logic                                 ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0]       ram_raddr,
  input  logic [TAG_BITS+SIZE_BITS-1:0]        ram_rdata
);

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LW  = (CW > dobq_pkg::ME_BITS) ? CW : dobq_pkg::ME_BITS;
  localparam int SW  = (CW > dobq_pkg::CNT_OUT_BITS) ? CW : dobq_pkg::CNT_OUT_BITS;
  localparam int BW  = ((SIZE_BITS > dobq_pkg::MB_BITS) ? SIZE_BITS : dobq_pkg::MB_BITS) + 1;
  localparam int TSW = AW + 2;
  localparam int CO  = dobq_pkg::CNT_OUT_BITS;
  localparam int QW  = dobq_pkg::SEQ_BITS;

  function automatic logic [CO-1:0] sat_cnt(input logic [CW-1:0] v);
    logic [SW-1:0] ext;
    ext = SW'(v);
    return (ext > SW'((1 << CO) - 1)) ? CO'((1 << CO) - 1) : ext[CO-1:0];
  endfunction

  dobq_pkg::state_t state, state_next;

  // queue state
  logic [AW-1:0]                    head;
  logic [CW-1:0]                    count;
  logic [SIZE_BITS-1:0]             bytes;
  logic [dobq_pkg::SEQ_BITS-1:0]    seq;
  // held item
  logic [dobq_pkg::OP_BITS-1:0]     op_q;
  logic [TAG_BITS-1:0]              tag_q;
  logic [SIZE_BITS-1:0]             size_q;
  logic [CW-1:0]                    ndrop;

  // derived
  logic                             out_free;
  logic                             empty;
  logic                             too_big;
  logic                             need_drop;
  logic [LW-1:0]                    me_ext;
  logic [LW-1:0]                    lim;
  logic [BW-1:0]                    byte_sum;
  logic [AW-1:0]                    head_inc;
  logic [TSW-1:0]                   tail_sum;
  logic [AW-1:0]                    tail;
  logic [SIZE_BITS-1:0]             rd_size;
  logic [TAG_BITS-1:0]              rd_tag;

  // control decode
  logic                             do_push;
  logic                             do_pop;
  logic                             res_load;
  logic [dobq_pkg::STATUS_BITS-1:0] res_status;
  logic [TAG_BITS-1:0]              res_tag;
  logic [SIZE_BITS-1:0]             res_size;
  logic [CO-1:0]                    res_dropped;
  logic [dobq_pkg::SEQ_BITS-1:0]    res_seq;
  logic [CO-1:0]                    res_count;
  logic [SIZE_BITS-1:0]             res_bytes;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == dobq_pkg::S_IDLE);
  assign empty    = (count == '0);

  // entry limit: zero acts as one, above depth acts as depth
  assign me_ext = LW'(cfg.max_entries);
  assign lim    = (cfg.max_entries == '0) ? LW'(1) :
                  (me_ext > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : me_ext;

  assign too_big   = BW'(size_q) > BW'(cfg.max_bytes);
  assign byte_sum  = BW'(bytes) + BW'(size_q);
  assign need_drop = !empty && ((LW'(count) >= lim) || (byte_sum > BW'(cfg.max_bytes)));

  assign head_inc = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
  assign tail_sum = TSW'(head) + TSW'(count);
  assign tail     = (tail_sum >= TSW'(QUEUE_DEPTH)) ? AW'(tail_sum - TSW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);

  assign rd_size = ram_rdata[SIZE_BITS-1:0];
  assign rd_tag  = ram_rdata[TAG_BITS+SIZE_BITS-1:SIZE_BITS];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dobq_pkg::S_IDLE: begin
        if (in_valid) state_next = dobq_pkg::S_EVAL;
      end
      dobq_pkg::S_EVAL: begin
        case (op_q) inside
          dobq_pkg::OP_PUT: begin
            if (!too_big && need_drop) state_next = dobq_pkg::S_DROP;
            else if (out_free)         state_next = dobq_pkg::S_IDLE;
          end
          dobq_pkg::OP_GET, dobq_pkg::OP_DISCARD: begin
            if (!empty)        state_next = dobq_pkg::S_POP;
            else if (out_free) state_next = dobq_pkg::S_IDLE;
          end
          default: begin
            if (out_free) state_next = dobq_pkg::S_IDLE;
          end
        endcase
      end
      dobq_pkg::S_DROP: state_next = dobq_pkg::S_EVAL;
      dobq_pkg::S_POP: begin
        if (out_free) state_next = dobq_pkg::S_IDLE;
      end
      default: state_next = dobq_pkg::S_IDLE;
    endcase
  end

  // datapath control and result assembly
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = tail;
    ram_wdata   = {tag_q, size_q};
    ram_re      = 1'b0;
    ram_raddr   = head;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    res_load    = 1'b0;
    res_status  = dobq_pkg::ST_OK;
    res_tag     = '0;
    res_size    = '0;
    res_dropped = '0;
    res_seq     = '0;
    res_count   = sat_cnt(count);
    res_bytes   = bytes;
    unique case (state)
      dobq_pkg::S_IDLE: ;
      dobq_pkg::S_EVAL: begin
        case (op_q) inside
          dobq_pkg::OP_PUT: begin
            if (too_big) begin
              res_load   = out_free;
              res_status = dobq_pkg::ST_TOO_BIG;
            end else if (need_drop) begin
              ram_re = 1'b1;
            end else begin
              res_load    = out_free;
              do_push     = out_free;
              ram_we      = out_free;
              res_dropped = sat_cnt(ndrop);
              res_seq     = seq + QW'(1);
              res_count   = sat_cnt(count + CW'(1));
              res_bytes   = bytes + size_q;
            end
          end
          dobq_pkg::OP_GET, dobq_pkg::OP_DISCARD: begin
            if (empty) begin
              res_load   = out_free;
              res_status = dobq_pkg::ST_EMPTY;
            end else begin
              ram_re = 1'b1;
            end
          end
          default: begin
            res_load = out_free;
          end
        endcase
      end
      dobq_pkg::S_DROP: begin
        do_pop = 1'b1;
      end
      dobq_pkg::S_POP: begin
        res_load  = out_free;
        do_pop    = out_free;
        res_count = sat_cnt(count - CW'(1));
        res_bytes = bytes - rd_size;
        if (op_q == dobq_pkg::OP_GET) begin
          res_tag  = rd_tag;
          res_size = rd_size;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dobq_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      bytes <= '0;
      seq   <= '0;
      ndrop <= '0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        ndrop <= '0;
      end else if (state == dobq_pkg::S_DROP) begin
        ndrop <= ndrop + CW'(1);
      end
      if (do_pop) begin
        head  <= head_inc;
        count <= count - CW'(1);
        bytes <= bytes - rd_size;
      end else if (do_push) begin
        count <= count + CW'(1);
        bytes <= bytes + size_q;
        seq   <= seq + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= operation;
      tag_q  <= item_tag;
      size_q <= item_size;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status      <= res_status;
      out_tag     <= res_tag;
      out_size    <= res_size;
      dropped     <= res_dropped;
      seq_number  <= res_seq;
      entry_count <= res_count;
      byte_total  <= res_bytes;
    end
  end

endmodule

// ----- test/drop_oldest_byte_budget_queue_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drop_oldest_byte_budget_queue_core_tb
// Directed table, then phased random traffic under changing entry/byte limits.
// Each result word is checked field by field against a ring model or a typed reply.
// ----------------------------------------------------------------------------
module drop_oldest_byte_budget_queue_core_tb;

  localparam int DEPTH  = dobq_pkg::QUEUE_DEPTH_DEF;
  localparam int TAG_W  = dobq_pkg::TAG_BITS_DEF;
  localparam int SIZE_W = dobq_pkg::SIZE_BITS_DEF;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = dobq_pkg::CNT_OUT_BITS;
  localparam int SEQ_W  = dobq_pkg::SEQ_BITS;

  localparam logic [dobq_pkg::OP_BITS-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [dobq_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam int PLAN_ROWS       = 30;
  localparam int PHASES          = 9;
  localparam int WORDS_PER_PHASE = 170;
  localparam int HOLD_AT_A       = 300;
  localparam int HOLD_AT_B       = 1200;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 140;
  localparam int TIMEOUT_NS      = 20_000_000;

  typedef struct packed {
    logic [dobq_pkg::STATUS_BITS-1:0] status;
    logic [TAG_W-1:0]                 tag;
    logic [SIZE_W-1:0]                size;
    logic [CNT_W-1:0]                 dropped;
    logic [SEQ_W-1:0]                 seq;
    logic [CNT_W-1:0]                 count;
    logic [SIZE_W-1:0]                bytes;
  } reply_t;

  typedef struct packed {
    logic               is_cfg;
    logic [1:0]         code;   // operation, or register index for a cfg row
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  value;  // item size, or register data
    logic               typed;
    reply_t             want;
  } plan_row_t;

  localparam logic   ROW_ITEM  = 1'b0;
  localparam logic   ROW_CFG   = 1'b1;
  localparam logic   TYPED     = 1'b1;
  localparam logic   PREDICTED = 1'b0;
  localparam reply_t NO_REPLY  = '0;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [dobq_pkg::CFG_IDX_BITS-1:0]     cfg_index = '0;
  logic [dobq_pkg::CFG_DAT_BITS-1:0]     cfg_data = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic [dobq_pkg::OP_BITS-1:0]          operation = '0;
  logic [TAG_W-1:0]                      item_tag = '0;
  logic [SIZE_W-1:0]                     item_size = '0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic [dobq_pkg::STATUS_BITS-1:0]      status;
  logic [TAG_W-1:0]                      out_tag;
  logic [SIZE_W-1:0]                     out_size;
  logic [CNT_W-1:0]                      dropped;
  logic [SEQ_W-1:0]                      seq_number;
  logic [CNT_W-1:0]                      entry_count;
  logic [SIZE_W-1:0]                     byte_total;

  int send_idle_pct = 38;
  int recv_idle_pct = 79;
  int mismatches = 0;

  reply_t pending_replies[$];

  // model of the descriptor ring and its limits
  logic [TAG_W-1:0]                 ring_tag[DEPTH];
  logic [SIZE_W-1:0]                ring_size[DEPTH];
  logic [PTR_W-1:0]                 ring_head = '0;
  int                               held_entries = 0;
  logic [SIZE_W-1:0]                held_sum = '0;
  logic [SEQ_W-1:0]                 seq_ctr = '0;
  logic [dobq_pkg::ME_BITS-1:0]     lim_entries = dobq_pkg::MAX_ENTRIES_RST;
  logic [dobq_pkg::MB_BITS-1:0]     lim_bytes = dobq_pkg::MAX_BYTES_RST;

  drop_oldest_byte_budget_queue_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .item_tag    (item_tag),
    .item_size   (item_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_tag     (out_tag),
    .out_size    (out_size),
    .dropped     (dropped),
    .seq_number  (seq_number),
    .entry_count (entry_count),
    .byte_total  (byte_total)
  );

  always #6 clk = ~clk;

  function automatic reply_t apply_queue_op(input logic [dobq_pkg::OP_BITS-1:0] op,
                                            input logic [TAG_W-1:0] tag,
                                            input logic [SIZE_W-1:0] size);
    reply_t r;
    int lim;
    logic [PTR_W-1:0] slot;
    r = '0;
    lim = (lim_entries == 0) ? 1 :
          (int'(lim_entries) > DEPTH) ? DEPTH : int'(lim_entries);
    case (op)
      dobq_pkg::OP_PUT: begin
        if (size > lim_bytes) begin
          r.status = dobq_pkg::ST_TOO_BIG;
        end else begin
          // evict from the head until one more entry and its bytes fit
          while (held_entries > 0 &&
                 (held_entries >= lim ||
                  int'(held_sum) + int'(size) > int'(lim_bytes))) begin
            held_sum = held_sum - ring_size[ring_head];
            ring_head = ring_head + PTR_W'(1);
            held_entries--;
            r.dropped = r.dropped + CNT_W'(1);
          end
          seq_ctr = seq_ctr + SEQ_W'(1);
          r.seq = seq_ctr;
          slot = ring_head + held_entries[PTR_W-1:0];
          ring_tag[slot] = tag;
          ring_size[slot] = size;
          held_entries++;
          held_sum = held_sum + size;
        end
      end
      dobq_pkg::OP_GET, dobq_pkg::OP_DISCARD: begin
        if (held_entries == 0) begin
          r.status = dobq_pkg::ST_EMPTY;
        end else begin
          if (op == dobq_pkg::OP_GET) begin
            r.tag = ring_tag[ring_head];
            r.size = ring_size[ring_head];
          end
          held_sum = held_sum - ring_size[ring_head];
          ring_head = ring_head + PTR_W'(1);
          held_entries--;
        end
      end
      default: ;
    endcase
    r.count = held_entries[CNT_W-1:0];
    r.bytes = held_sum;
    return r;
  endfunction

  function automatic reply_t typed_reply(input logic [dobq_pkg::STATUS_BITS-1:0] st,
                                         input logic [SEQ_W-1:0] seq,
                                         input logic [CNT_W-1:0] cnt);
    reply_t r;
    r = '0;
    r.status = st;
    r.seq = seq;
    r.count = cnt;
    return r;
  endfunction

  function automatic plan_row_t plan_row(input int i);
    case (i)
      // empty pops and the unused code right after reset, then puts around the byte limit
      0:  return {ROW_ITEM, dobq_pkg::OP_GET, 16'h0000, 20'h00000, TYPED,
                  typed_reply(dobq_pkg::ST_EMPTY, 0, 0)};
      1:  return {ROW_ITEM, dobq_pkg::OP_DISCARD, 16'h0000, 20'h00000, TYPED,
                  typed_reply(dobq_pkg::ST_EMPTY, 0, 0)};
      2:  return {ROW_ITEM, OP_UNUSED, 16'hFFFF, 20'hFFFFF, TYPED,
                  typed_reply(dobq_pkg::ST_OK, 0, 0)};
      3:  return {ROW_ITEM, dobq_pkg::OP_PUT, 16'hFFFF, 20'h00000, TYPED,
                  typed_reply(dobq_pkg::ST_OK, 1, 1)};
      4:  return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h0000, 20'd262145, TYPED,
                  typed_reply(dobq_pkg::ST_TOO_BIG, 0, 1)};
      5:  return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h1234, 20'd262144, PREDICTED, NO_REPLY};
      6:  return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h4321, 20'd1, PREDICTED, NO_REPLY};
      7:  return {ROW_ITEM, dobq_pkg::OP_GET, 16'h0000, 20'h00000, PREDICTED, NO_REPLY};
      8:  return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h0000, 20'hFFFFF, TYPED,
                  typed_reply(dobq_pkg::ST_TOO_BIG, 0, 0)};
      9:  return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h0001, 20'd5, PREDICTED, NO_REPLY};
      10: return {ROW_ITEM, dobq_pkg::OP_DISCARD, 16'h0000, 20'h00000, PREDICTED, NO_REPLY};
      // zero byte budget: only empty messages get in
      11: return {ROW_CFG, dobq_pkg::REG_MAX_BYTES, 16'h0000, 20'h00000, PREDICTED, NO_REPLY};
      12: return {ROW_ITEM, dobq_pkg::OP_PUT, 16'hBEEF, 20'd0, PREDICTED, NO_REPLY};
      13: return {ROW_ITEM, dobq_pkg::OP_PUT, 16'hBEEF, 20'd1, TYPED,
                  typed_reply(dobq_pkg::ST_TOO_BIG, 0, 1)};
      // entry limit 0 behaves as 1
      14: return {ROW_CFG, dobq_pkg::REG_MAX_BYTES, 16'h0000, 20'hFFFFF, PREDICTED, NO_REPLY};
      15: return {ROW_CFG, dobq_pkg::REG_MAX_ENTRIES, 16'h0000, 20'h00000, PREDICTED,
                  NO_REPLY};
      16: return {ROW_ITEM, dobq_pkg::OP_PUT, 16'hAAAA, 20'hFFFFF, PREDICTED, NO_REPLY};
      17: return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h5555, 20'd7, PREDICTED, NO_REPLY};
      // entry limit above depth, then both limits cut below what is held
      18: return {ROW_CFG, dobq_pkg::REG_MAX_ENTRIES, 16'h0000, 20'd127, PREDICTED, NO_REPLY};
      19: return {ROW_CFG, dobq_pkg::REG_MAX_BYTES, 16'h0000, 20'd1000, PREDICTED, NO_REPLY};
      20: return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h0101, 20'd300, PREDICTED, NO_REPLY};
      21: return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h0202, 20'd300, PREDICTED, NO_REPLY};
      22: return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h0404, 20'd300, PREDICTED, NO_REPLY};
      23: return {ROW_CFG, dobq_pkg::REG_MAX_ENTRIES, 16'h0000, 20'hABC02, PREDICTED,
                  NO_REPLY};
      24: return {ROW_CFG, dobq_pkg::REG_MAX_BYTES, 16'h0000, 20'd500, PREDICTED, NO_REPLY};
      25: return {ROW_CFG, REG_UNUSED, 16'h0000, 20'hFFFFF, PREDICTED, NO_REPLY};
      26: return {ROW_ITEM, dobq_pkg::OP_PUT, 16'h0808, 20'd10, PREDICTED, NO_REPLY};
      27: return {ROW_ITEM, dobq_pkg::OP_GET, 16'h0000, 20'h00000, PREDICTED, NO_REPLY};
      28: return {ROW_ITEM, dobq_pkg::OP_GET, 16'h0000, 20'h00000, PREDICTED, NO_REPLY};
      29: return {ROW_ITEM, dobq_pkg::OP_GET, 16'h0000, 20'h00000, PREDICTED, NO_REPLY};
      default: return '0;
    endcase
  endfunction

  task automatic write_reg(input logic [dobq_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [dobq_pkg::CFG_DAT_BITS-1:0] data);
    in_valid <= 1'b0;
    // registers change only with every result word drained
    do @(negedge clk); while (pending_replies.size() != 0);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      dobq_pkg::REG_MAX_ENTRIES: lim_entries = data[dobq_pkg::ME_BITS-1:0];
      dobq_pkg::REG_MAX_BYTES:   lim_bytes = data[dobq_pkg::MB_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [dobq_pkg::OP_BITS-1:0] op,
                           input logic [TAG_W-1:0] tag,
                           input logic [SIZE_W-1:0] size, input logic use_typed,
                           input reply_t typed);
    reply_t model;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    operation <= op;
    item_tag <= tag;
    item_size <= size;
    do @(posedge clk); while (!in_ready);
    model = apply_queue_op(op, tag, size);
    pending_replies.push_back(use_typed ? typed : model);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  initial begin : result_side
    reply_t want, got;
    int taken;
    taken = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = {status, out_tag, out_size, dropped, seq_number, entry_count, byte_total};
        taken++;
        if (pending_replies.size() == 0) begin
          mismatches++;
          $display("%0t ns: result word with none pending, expected none, got %h",
                   $time, got);
        end else begin
          want = pending_replies.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("out_tag", 32'(want.tag), 32'(got.tag));
          report_field("out_size", 32'(want.size), 32'(got.size));
          report_field("dropped", 32'(want.dropped), 32'(got.dropped));
          report_field("seq_number", want.seq, got.seq);
          report_field("entry_count", 32'(want.count), 32'(got.count));
          report_field("byte_total", 32'(want.bytes), 32'(got.bytes));
        end
        if (taken == HOLD_AT_A || taken == HOLD_AT_B) begin
          // long stall: result register stays full and backs up the input side
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    plan_row_t row;
    logic [dobq_pkg::OP_BITS-1:0] op;
    logic [TAG_W-1:0] tag;
    logic [SIZE_W-1:0] size;
    logic [dobq_pkg::CFG_DAT_BITS-1:0] ph_entries, ph_bytes;
    int pick;
    bit filling;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = plan_row(i);
      if (row.is_cfg)
        write_reg(row.code, row.value);
      else
        send_word(row.code, row.tag, row.value, row.typed, row.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ph_entries = 64;  ph_bytes = 262144;  end
        1: begin ph_entries = 8;   ph_bytes = 4096;    end
        2: begin ph_entries = 1;   ph_bytes = 1048575; end
        3: begin ph_entries = 127; ph_bytes = 1048575; end
        4: begin ph_entries = 3;   ph_bytes = 100;     end
        5: begin ph_entries = 64;  ph_bytes = 1;       end
        6: begin ph_entries = 16;  ph_bytes = 0;       end
        7: begin ph_entries = 40;  ph_bytes = 50000;   end
        default: begin ph_entries = 0; ph_bytes = 777; end
      endcase
      write_reg(dobq_pkg::REG_MAX_ENTRIES, ph_entries);
      write_reg(dobq_pkg::REG_MAX_BYTES, ph_bytes);
      // switch idle pattern away from the active edge
      @(negedge clk);
      send_idle_pct = (p < 3) ? 38 : (p < 6) ? 79 : 0;
      recv_idle_pct = (p < 3) ? 79 : (p < 6) ? 38 : 0;
      @(posedge clk);

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // alternate put-heavy and pop-heavy stretches so the ring fills and wraps
        filling = ((n / 40) % 2) == 0;
        pick = $urandom_range(99);
        if (pick < 4)
          op = OP_UNUSED;
        else if (pick < (filling ? 74 : 34))
          op = dobq_pkg::OP_PUT;
        else if (pick < (filling ? 88 : 80))
          op = dobq_pkg::OP_GET;
        else
          op = dobq_pkg::OP_DISCARD;
        tag = TAG_W'($urandom_range(16'hFFFF));
        case ($urandom_range(15))
          0: size = '0;
          1: size = lim_bytes;
          2: size = (lim_bytes == '1) ? lim_bytes : lim_bytes + SIZE_W'(1);
          3: size = SIZE_W'($urandom_range(20'hFFFFF));
          4: size = '1;
          5, 6, 7, 8, 9: size = SIZE_W'($urandom_range(lim_bytes >> 3));
          default: size = SIZE_W'($urandom_range(lim_bytes >> 7));
        endcase
        send_word(op, tag, size, 1'b0, NO_REPLY);
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_replies.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("drop_oldest_byte_budget_queue_core: match");
    end else begin
      $display("drop_oldest_byte_budget_queue_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("drop_oldest_byte_budget_queue_core: mismatch");
    $finish;
  end

endmodule
